// ===== hdl/sacr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacr_pkg
// shared types and codes of the cache tag and replacement engine
// ----------------------------------------------------------------------------
package sacr_pkg;

	localparam int unsigned TAG_W     = 20;
	localparam int unsigned WAY_W     = 3;
	localparam int unsigned POL_W     = 3;
	localparam int unsigned RRPV_W    = 4;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DUEL_MOD  = 5;

	localparam logic [POL_W-1:0] POL_RANDOM = 3'd0;
	localparam logic [POL_W-1:0] POL_LRU    = 3'd1;
	localparam logic [POL_W-1:0] POL_LFU    = 3'd2;
	localparam logic [POL_W-1:0] POL_SRRIPH = 3'd3;
	localparam logic [POL_W-1:0] POL_SRRIPF = 3'd4;
	localparam logic [POL_W-1:0] POL_BRRIP  = 3'd5;
	localparam logic [POL_W-1:0] POL_DRRIP  = 3'd6;
	localparam logic [POL_W-1:0] POL_SPARE  = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RRPV_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WTHROUGH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WALLOC    = 2'd3;

	typedef struct packed {
		logic        func;
		logic [31:0] address;
		logic [2:0]  random_way;
		logic        distant_insert;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic              line_fill;
		logic              mem_write;
		logic              dirty_evict;
		logic [TAG_W-1:0]  victim_tag;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic rd_set;
		logic lookup;
		logic age;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_age;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/sacr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacr_ctrl
// access sequencer: capture, set read, lookup, optional aging, commit
// ----------------------------------------------------------------------------
module sacr_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   out_valid,
	input  wire                   out_stall,
	input  sacr_pkg::sts_t        sts,
	output sacr_pkg::cmd_t        cmd
);
	import sacr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_LOOK = 5'b00100,
		S_AGE  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// a finished result may wait in the output register while the next
	// transaction is read; commit only once the output register is free
	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.capture = in_valid;
			S_READ: cmd.rd_set = 1'b1;
			S_LOOK: cmd.lookup = 1'b1;
			S_AGE:  cmd.age = 1'b1;
			S_DONE: cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_LOOK;
				S_LOOK: state_q <= sts.need_age ? S_AGE : S_DONE;
				S_AGE:  state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sacr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacr_dp
// set memories, tag compare, victim choice and replacement state update
// ----------------------------------------------------------------------------
module sacr_dp #(
	parameter int unsigned SETS       = 64,
	parameter int unsigned WAYS       = 8,
	parameter int unsigned LINE_BYTES = 64,
	parameter int unsigned ADDR_BITS  = 32,
	parameter int unsigned PSEL_BITS  = 10
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sacr_pkg::req_t       req,
	input  sacr_pkg::cmd_t       cmd,
	output sacr_pkg::sts_t       sts,
	input  wire                  cfg_we,
	input  sacr_pkg::cfg_t       cfg,
	output logic                 clr_busy,
	output logic                 res_valid,
	input  wire                  res_stall,
	output sacr_pkg::rsp_t       res
);
	import sacr_pkg::*;

	localparam int unsigned LS    = $clog2(LINE_BYTES);
	localparam int unsigned SS    = $clog2(SETS);
	localparam int unsigned WI    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned RANKW = WI;
	localparam logic signed [PSEL_BITS-1:0] PMAX = {1'b0, {(PSEL_BITS-1){1'b1}}};
	localparam logic signed [PSEL_BITS-1:0] PMIN = {1'b1, {(PSEL_BITS-1){1'b0}}};

	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [TAG_W-1:0]  tag;
		logic [RANKW-1:0]  rank;
		logic [CNT_W-1:0]  cnt;
		logic [RRPV_W-1:0] rrpv;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	row_t                   mem_q [SETS];
	logic [SS-1:0]          clr_idx_q;
	logic                   clr_busy_q;

	logic [POL_W-1:0]       policy_q;
	logic [2:0]             rrpv_bits_q;
	logic                   wthru_q;
	logic                   walloc_q;
	logic signed [PSEL_BITS-1:0] psel_q;

	req_t                   req_s1;
	row_t                   row_s2;
	logic                   hit_s3;
	logic [WI-1:0]          hway_s3;
	logic [WI-1:0]          vway_s3;
	logic [POL_W-1:0]       pol_s3;
	logic [RRPV_W-1:0]      delta_s3;

	logic                   rv_q;
	rsp_t                   res_q;

	// decode
	logic [SS-1:0]          set_idx;
	logic [TAG_W-1:0]       tag_in;
	logic [ADDR_BITS-1:0]   addr;
	logic [2:0]             m;
	logic [RRPV_W-1:0]      dist_rrpv;
	logic [POL_W-1:0]       pol_base;
	logic [DUEL_MOD-1:0]    duel;

	assign addr    = ADDR_BITS'(req_s1.address);
	assign set_idx = addr[LS +: SS];
	assign tag_in  = TAG_W'(addr >> (LS + SS));
	assign m       = (rrpv_bits_q < 3'd1) ? 3'd1 : ((rrpv_bits_q > 3'd4) ? 3'd4 : rrpv_bits_q);
	assign dist_rrpv = RRPV_W'((5'd1 << m) - 5'd1);
	assign duel    = DUEL_MOD'(set_idx);
	assign pol_base = (policy_q == POL_SPARE) ? POL_LRU : policy_q;

	logic [POL_W-1:0] pol_eff;
	always_comb begin
		pol_eff = pol_base;
		if (pol_base == POL_DRRIP) begin
			if (duel == '0) pol_eff = POL_BRRIP;
			else if (duel == DUEL_MOD'(1)) pol_eff = POL_SRRIPH;
			else pol_eff = (psel_q > 0) ? POL_BRRIP : POL_SRRIPH;
		end
	end

	// random way folded onto the way count
	logic [WI-1:0] rnd_w;
	always_comb begin
		rnd_w = '0;
		for (int k = 0; k < 8; k++)
			if (req_s1.random_way == 3'(k)) rnd_w = WI'(k % WAYS);
	end

	// lookup logic on the read row
	logic              hit_c;
	logic [WI-1:0]     hway_c;
	logic              inv_c;
	logic [WI-1:0]     inv_w;
	logic [WI-1:0]     lru_w;
	logic [RANKW-1:0]  lru_mx;
	logic [WI-1:0]     lfu_w;
	logic [CNT_W-1:0]  lfu_mn;
	logic              dst_c;
	logic [WI-1:0]     dst_w;
	logic [RRPV_W-1:0] rr_mx;
	logic [WI-1:0]     vway_c;
	logic              age_c;

	always_comb begin
		hit_c = 1'b0; hway_c = '0; inv_c = 1'b0; inv_w = '0;
		lru_w = '0; lru_mx = '0; lfu_w = '0; lfu_mn = '1;
		dst_c = 1'b0; dst_w = '0; rr_mx = '0;
		for (int j = WAYS-1; j >= 0; j--) begin
			if (row_s2[j].valid && row_s2[j].tag == tag_in) begin
				hit_c = 1'b1; hway_c = WI'(j);
			end
			if (!row_s2[j].valid) begin
				inv_c = 1'b1; inv_w = WI'(j);
			end
			if (row_s2[j].rrpv >= dist_rrpv) begin
				dst_c = 1'b1; dst_w = WI'(j);
			end
			if (row_s2[j].rrpv > rr_mx) rr_mx = row_s2[j].rrpv;
		end
		for (int j = 0; j < WAYS; j++) begin
			if (row_s2[j].rank > lru_mx) begin
				lru_mx = row_s2[j].rank; lru_w = WI'(j);
			end
			if (j == 0 || row_s2[j].cnt < lfu_mn) begin
				lfu_mn = row_s2[j].cnt; lfu_w = WI'(j);
			end
		end
		age_c = 1'b0;
		if (inv_c) begin
			vway_c = inv_w;
		end else begin
			case (pol_eff)
				POL_RANDOM: vway_c = rnd_w;
				POL_LRU:    vway_c = lru_w;
				POL_LFU:    vway_c = lfu_w;
				default: begin
					vway_c = dst_w;
					age_c  = !dst_c;
				end
			endcase
		end
	end

	// aging pass: first way holding the largest rrpv becomes distant
	logic [WI-1:0] mx_w;
	always_comb begin
		mx_w = '0;
		for (int j = WAYS-1; j >= 0; j--)
			if (row_s2[j].rrpv == rr_mx) mx_w = WI'(j);
	end

	logic miss_alloc;
	assign miss_alloc = !hit_s3 && !(req_s1.func && !walloc_q);
	assign sts.need_age = age_c && (req_s1.func ? walloc_q : 1'b1) && !hit_c;

	// commit
	row_t          row_n;
	logic [WI-1:0] w_u;
	logic [RANKW-1:0] r_ref;
	rsp_t          rsp_n;
	always_comb begin
		row_n = row_s2;
		rsp_n = '0;
		w_u   = hit_s3 ? hway_s3 : vway_s3;
		r_ref = row_s2[w_u].rank;
		rsp_n.hit = hit_s3;
		if (hit_s3) begin
			rsp_n.way = WAY_W'(hway_s3);
			if (req_s1.func) begin
				if (wthru_q) rsp_n.mem_write = 1'b1;
				else row_n[w_u].dirty = 1'b1;
			end
			case (pol_s3)
				POL_LRU: begin
					for (int j = 0; j < WAYS; j++)
						if (row_s2[j].valid && row_s2[j].rank < r_ref)
							row_n[j].rank = row_s2[j].rank + 1'b1;
					row_n[w_u].rank = '0;
				end
				POL_LFU: if (row_s2[w_u].cnt != '1) row_n[w_u].cnt = row_s2[w_u].cnt + 1'b1;
				POL_SRRIPH, POL_BRRIP: row_n[w_u].rrpv = '0;
				POL_SRRIPF: if (row_s2[w_u].rrpv != '0)
					row_n[w_u].rrpv = row_s2[w_u].rrpv - 1'b1;
				default: ;
			endcase
		end else if (!miss_alloc) begin
			rsp_n.mem_write = 1'b1;
		end else begin
			rsp_n.way = WAY_W'(vway_s3);
			rsp_n.line_fill = 1'b1;
			if (row_s2[w_u].valid && row_s2[w_u].dirty) begin
				rsp_n.dirty_evict = 1'b1;
				rsp_n.victim_tag = row_s2[w_u].tag;
			end
			row_n[w_u].tag = tag_in;
			row_n[w_u].valid = 1'b1;
			row_n[w_u].dirty = req_s1.func && !wthru_q;
			rsp_n.mem_write = req_s1.func && wthru_q;
			case (pol_s3)
				POL_LRU: begin
					for (int j = 0; j < WAYS; j++)
						if (row_s2[j].valid && row_s2[j].rank < r_ref)
							row_n[j].rank = row_s2[j].rank + 1'b1;
					row_n[w_u].rank = '0;
				end
				POL_LFU: row_n[w_u].cnt = CNT_W'(1);
				POL_SRRIPH, POL_SRRIPF: row_n[w_u].rrpv = dist_rrpv - 1'b1;
				POL_BRRIP: row_n[w_u].rrpv = req_s1.distant_insert ? dist_rrpv : dist_rrpv - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_s1 <= req;
		if (cmd.rd_set) row_s2 <= mem_q[set_idx];
		if (cmd.lookup) begin
			hit_s3 <= hit_c;
			hway_s3 <= hway_c;
			vway_s3 <= vway_c;
			pol_s3 <= pol_eff;
			delta_s3 <= dist_rrpv - rr_mx;
		end
		if (cmd.age) begin
			for (int j = 0; j < WAYS; j++)
				row_s2[j].rrpv <= row_s2[j].rrpv + delta_s3;
			vway_s3 <= mx_w;
		end
		if (cmd.commit) res_q <= rsp_n;
		if (clr_busy_q) begin
			for (int j = 0; j < WAYS; j++) begin
				mem_q[clr_idx_q][j].valid <= 1'b0;
				mem_q[clr_idx_q][j].dirty <= 1'b0;
				mem_q[clr_idx_q][j].tag   <= '0;
				mem_q[clr_idx_q][j].rank  <= RANKW'(j);
				mem_q[clr_idx_q][j].cnt   <= '0;
				mem_q[clr_idx_q][j].rrpv  <= '0;
			end
		end else if (cmd.commit) begin
			mem_q[set_idx] <= row_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_LRU;
			rrpv_bits_q <= 3'd2;
			wthru_q     <= 1'b0;
			walloc_q    <= 1'b1;
			psel_q      <= '0;
			rv_q        <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SS'(SETS-1)) clr_busy_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg.index)
					REG_POLICY:    policy_q <= cfg.data[2:0];
					REG_RRPV_BITS: rrpv_bits_q <= cfg.data[2:0];
					REG_WTHROUGH:  wthru_q <= cfg.data[0];
					REG_WALLOC:    walloc_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (cmd.commit && miss_alloc && policy_q == POL_DRRIP) begin
				if (duel == DUEL_MOD'(1) && psel_q < PMAX) psel_q <= psel_q + 1'b1;
				else if (duel == '0 && psel_q > PMIN) psel_q <= psel_q - 1'b1;
			end
			if (cmd.commit) rv_q <= 1'b1;
			else if (!res_stall) rv_q <= 1'b0;
		end
	end

	assign clr_busy  = clr_busy_q;
	assign res_valid = rv_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== hdl/set_assoc_cache_rrip_replacement.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_rrip_replacement
// tag and replacement engine of a set-associative cache
// ----------------------------------------------------------------------------
// One transaction at a time: capture, set read, lookup, commit. Commit waits
// while a stalled result holds the output register. An allocating miss
// under an RRIP policy whose set holds no distant and no invalid line takes
// an aging pass before commit. The set memory is one row of all ways read
// and written per transaction. While a clearing pass walks all sets after
// reset no transaction is accepted; configuration writes are taken at once.
module set_assoc_cache_rrip_replacement #(
	parameter int unsigned SETS       = 64,
	parameter int unsigned WAYS       = 8,
	parameter int unsigned LINE_BYTES = 64,
	parameter int unsigned ADDR_BITS  = 32,
	parameter int unsigned PSEL_BITS  = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  sacr_pkg::req_t      in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output sacr_pkg::rsp_t      out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  sacr_pkg::cfg_t      cfg_data
);
	import sacr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic ctrl_stall;

	sacr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && !busy),
		.in_stall  (ctrl_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sacr_dp #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.LINE_BYTES (LINE_BYTES),
		.ADDR_BITS  (ADDR_BITS),
		.PSEL_BITS  (PSEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid),
		.cfg       (cfg_data),
		.clr_busy  (busy),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (out_data)
	);

	assign in_stall  = ctrl_stall || busy;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ===== hdl/sacr_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sacr_chk
// port-level checks of the cache engine
// ----------------------------------------------------------------------------
module sacr_chk (
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_stall,
	input wire             out_valid,
	input wire             out_stall,
	input sacr_pkg::rsp_t  out_data
);
	import sacr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while busy");

	a_hit_nofill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> !out_data.line_fill && !out_data.dirty_evict)
		else $error("hit reported a fill");

	a_evict_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.dirty_evict |-> out_data.line_fill)
		else $error("eviction without fill");

endmodule

bind set_assoc_cache_rrip_replacement sacr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

// ===== test/tb_set_assoc_cache_rrip_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_rrip_replacement
// self-checking bench for the cache tag and replacement engine
// ----------------------------------------------------------------------------
// A short table of directed accesses runs first under the reset settings.
// Random phases follow, each with its own register settings. Addresses come
// mostly from a small pool of tags over a handful of sets, so hits,
// evictions and the dueling leader sets are reached often. Every accepted
// access is run through a local model of the tag store, and each response
// is compared field by field with the oldest prediction.
module tb_set_assoc_cache_rrip_replacement;
	import sacr_pkg::*;

	localparam int NSETS    = 64;
	localparam int NWAYS    = 8;
	localparam int PSEL_W   = 10;
	localparam int LIMIT    = 600000;

	typedef struct {
		req_t req;
		bit   fixed;
		rsp_t rsp;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	cfg_t cfg_data;

	// model state
	logic [2:0]  m_policy;
	logic [2:0]  m_rrpv_bits;
	logic        m_wthrough;
	logic        m_walloc;
	bit          m_valid [NSETS*NWAYS];
	bit          m_dirty [NSETS*NWAYS];
	logic [19:0] m_tag   [NSETS*NWAYS];
	int unsigned m_rank  [NSETS*NWAYS];
	int unsigned m_count [NSETS*NWAYS];
	int unsigned m_rrpv  [NSETS*NWAYS];
	int          m_psel;

	rsp_t        pending_rsp[$];
	int          errors;
	int          cycles;
	bit          quiet;
	logic [19:0] tag_pool [12];
	row_t        directed [$];

	set_assoc_cache_rrip_replacement u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void model_reset();
		m_policy    = POL_LRU;
		m_rrpv_bits = 3'd2;
		m_wthrough  = 1'b0;
		m_walloc    = 1'b1;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			m_valid[i] = 1'b0;
			m_dirty[i] = 1'b0;
			m_tag[i]   = '0;
			m_rank[i]  = i % NWAYS;
			m_count[i] = 0;
			m_rrpv[i]  = 0;
		end
		m_psel = 0;
	endfunction

	function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		case (idx)
			REG_POLICY:    m_policy    = val[2:0];
			REG_RRPV_BITS: m_rrpv_bits = val[2:0];
			REG_WTHROUGH:  m_wthrough  = val[0];
			REG_WALLOC:    m_walloc    = val[0];
			default: ;
		endcase
	endfunction

	function automatic void touch_recency(int base, int w);
		int unsigned r;
		r = m_rank[base+w];
		for (int j = 0; j < NWAYS; j++)
			if (m_valid[base+j] && m_rank[base+j] < r)
				m_rank[base+j]++;
		m_rank[base+w] = 0;
	endfunction

	function automatic int choose_victim(int base, logic [2:0] pol, int unsigned dist_rrpv,
			logic [2:0] rway);
		int unsigned mx;
		int unsigned mn;
		int v;
		v = 0;
		for (int j = 0; j < NWAYS; j++)
			if (!m_valid[base+j]) return j;
		if (pol == POL_RANDOM) return rway % NWAYS;
		if (pol == POL_LRU) begin
			mx = 0;
			for (int j = 0; j < NWAYS; j++)
				if (m_rank[base+j] > mx) begin
					mx = m_rank[base+j];
					v = j;
				end
			return v;
		end
		if (pol == POL_LFU) begin
			mn = 32'hFFFF_FFFF;
			for (int j = 0; j < NWAYS; j++)
				if (m_count[base+j] < mn) begin
					mn = m_count[base+j];
					v = j;
				end
			return v;
		end
		for (int j = 0; j < NWAYS; j++)
			if (m_rrpv[base+j] >= dist_rrpv) return j;
		mx = 0;
		for (int j = 0; j < NWAYS; j++)
			if (m_rrpv[base+j] > mx) mx = m_rrpv[base+j];
		for (int j = 0; j < NWAYS; j++)
			m_rrpv[base+j] += dist_rrpv - mx;
		for (int j = 0; j < NWAYS; j++)
			if (m_rrpv[base+j] >= dist_rrpv) return j;
		return 0;
	endfunction

	function automatic rsp_t cache_access(req_t r);
		rsp_t        o;
		int          set_i;
		int          base;
		int          w;
		int          i;
		int unsigned m;
		int unsigned dist_rrpv;
		logic [2:0]  pol;
		logic [4:0]  duel;
		logic [19:0] tg;
		int          pmax;
		bit          hit;
		o     = '0;
		set_i = r.address[11:6];
		tg    = r.address[31:12];
		base  = set_i * NWAYS;
		m     = m_rrpv_bits < 1 ? 1 : (m_rrpv_bits > 4 ? 4 : m_rrpv_bits);
		dist_rrpv = (1 << m) - 1;
		pol   = (m_policy == POL_SPARE) ? POL_LRU : m_policy;
		duel  = set_i[4:0];
		pmax  = (1 << (PSEL_W-1)) - 1;
		hit   = 1'b0;
		w     = 0;
		if (pol == POL_DRRIP) begin
			if (duel == 0) pol = POL_BRRIP;
			else if (duel == 1) pol = POL_SRRIPH;
			else pol = (m_psel > 0) ? POL_BRRIP : POL_SRRIPH;
		end
		for (int j = 0; j < NWAYS; j++)
			if (!hit && m_valid[base+j] && m_tag[base+j] == tg) begin
				hit = 1'b1;
				w = j;
			end
		if (hit) begin
			i = base + w;
			if (r.func) begin
				if (m_wthrough) o.mem_write = 1'b1;
				else m_dirty[i] = 1'b1;
			end
			case (pol)
				POL_LRU:    touch_recency(base, w);
				POL_LFU:    if (m_count[i] < 16'hFFFF) m_count[i]++;
				POL_SRRIPH,
				POL_BRRIP:  m_rrpv[i] = 0;
				POL_SRRIPF: if (m_rrpv[i] != 0) m_rrpv[i]--;
				default: ;
			endcase
		end else if (r.func && !m_walloc) begin
			o.mem_write = 1'b1;
		end else begin
			w = choose_victim(base, pol, dist_rrpv, r.random_way);
			i = base + w;
			if (m_valid[i] && m_dirty[i]) begin
				o.dirty_evict = 1'b1;
				o.victim_tag  = m_tag[i];
			end
			o.line_fill = 1'b1;
			m_tag[i]   = tg;
			m_valid[i] = 1'b1;
			m_dirty[i] = 1'b0;
			if (r.func) begin
				if (m_wthrough) o.mem_write = 1'b1;
				else m_dirty[i] = 1'b1;
			end
			case (pol)
				POL_LRU:    touch_recency(base, w);
				POL_LFU:    m_count[i] = 1;
				POL_SRRIPH,
				POL_SRRIPF: m_rrpv[i] = dist_rrpv - 1;
				POL_BRRIP:  m_rrpv[i] = r.distant_insert ? dist_rrpv : dist_rrpv - 1;
				default: ;
			endcase
			if (m_policy == POL_DRRIP) begin
				if (duel == 1 && m_psel < pmax) m_psel++;
				else if (duel == 0 && m_psel > -pmax - 1) m_psel--;
			end
		end
		o.hit = hit;
		o.way = w[2:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// response checker and back-pressure
	always @(posedge clk) begin
		rsp_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected transaction", 32'(out_data), 32'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
				if (out_data.way !== want.way)
					report_mismatch("way", 32'(out_data.way), 32'(want.way));
				if (out_data.line_fill !== want.line_fill)
					report_mismatch("line_fill", 32'(out_data.line_fill),
						32'(want.line_fill));
				if (out_data.mem_write !== want.mem_write)
					report_mismatch("mem_write", 32'(out_data.mem_write),
						32'(want.mem_write));
				if (out_data.dirty_evict !== want.dirty_evict)
					report_mismatch("dirty_evict", 32'(out_data.dirty_evict),
						32'(want.dirty_evict));
				if (out_data.victim_tag !== want.victim_tag)
					report_mismatch("victim_tag", 32'(out_data.victim_tag),
						32'(want.victim_tag));
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 8);
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_access(req_t r, bit fixed, rsp_t want);
		rsp_t pred;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = cache_access(r);
		if (fixed && pred != want)
			report_mismatch("directed row vs local model", 32'(pred), 32'(want));
		pending_rsp.push_back(fixed ? want : pred);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_data  <= '{index: idx, data: val};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_config(idx, val);
	endtask

	task automatic drain();
		while (pending_rsp.size() != 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b0;
		repeat (8) @(posedge clk);
	endtask

	function automatic req_t random_access();
		req_t r;
		int   pick;
		logic [5:0] set_i;
		r = '0;
		r.func           = 1'($urandom_range(0, 1));
		r.random_way     = 3'($urandom_range(0, 7));
		r.distant_insert = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 5);
		case (pick)
			0: set_i = 6'd0;
			1: set_i = 6'd1;
			2: set_i = 6'd32;
			3: set_i = 6'd33;
			4: set_i = 6'd7;
			default: set_i = 6'($urandom_range(0, NSETS-1));
		endcase
		r.address[11:6] = set_i;
		r.address[5:0]  = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 9) == 0) r.address[31:12] = 20'($urandom);
		else r.address[31:12] = tag_pool[$urandom_range(0, 11)];
		return r;
	endfunction

	function automatic req_t mk(logic f, logic [31:0] a, logic [2:0] rw, logic di);
		req_t r;
		r.func = f;
		r.address = a;
		r.random_way = rw;
		r.distant_insert = di;
		return r;
	endfunction

	function automatic rsp_t mkr(logic h, logic [2:0] w, logic lf, logic mw);
		rsp_t o;
		o = '0;
		o.hit = h;
		o.way = w;
		o.line_fill = lf;
		o.mem_write = mw;
		return o;
	endfunction

	initial begin
		logic [2:0] pol;
		logic [7:0] rb;
		int         n;
		errors    = 0;
		cycles    = 0;
		quiet     = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		model_reset();
		for (int i = 0; i < 12; i++) tag_pool[i] = 20'($urandom);
		tag_pool[0] = 20'h00000;
		tag_pool[1] = 20'hFFFFF;

		// reset settings: lru, write-back, write-allocate
		directed.push_back('{mk(1'b0, 32'h0000_0000, 3'd0, 1'b0), 1'b1,
			mkr(1'b0, 3'd0, 1'b1, 1'b0)});
		directed.push_back('{mk(1'b1, 32'h0000_003F, 3'd7, 1'b1), 1'b1,
			mkr(1'b1, 3'd0, 1'b0, 1'b0)});
		directed.push_back('{mk(1'b0, 32'hFFFF_FFFF, 3'd7, 1'b1), 1'b1,
			mkr(1'b0, 3'd0, 1'b1, 1'b0)});
		directed.push_back('{mk(1'b1, 32'hFFFF_FFC0, 3'd0, 1'b0), 1'b1,
			mkr(1'b1, 3'd0, 1'b0, 1'b0)});
		directed.push_back('{mk(1'b0, 32'h0000_1000, 3'd0, 1'b0), 1'b1,
			mkr(1'b0, 3'd1, 1'b1, 1'b0)});
		// overfill set 5 with dirty lines so lru evictions write back
		for (int i = 0; i < 10; i++)
			directed.push_back('{mk(1'b1, {i[19:0] + 20'h80000, 12'h140}, i[2:0], 1'b0),
				1'b0, '0});
		directed.push_back('{mk(1'b0, 32'h8000_0140, 3'd0, 1'b0), 1'b0, '0});
		directed.push_back('{mk(1'b1, 32'h8000_3140, 3'd0, 1'b1), 1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) send_access(directed[k].req, directed[k].fixed, directed[k].rsp);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			pol = (ph < 8) ? ph[2:0] : 3'($urandom_range(3, 6));
			case (ph % 6)
				0: rb = 8'd1;
				1: rb = 8'd4;
				2: rb = 8'd0;
				3: rb = 8'd7;
				4: rb = 8'd2;
				default: rb = 8'($urandom_range(0, 7));
			endcase
			quiet = (ph == 5);
			write_reg(REG_POLICY, {5'($urandom_range(0, 31)), pol});
			write_reg(REG_RRPV_BITS, {5'($urandom_range(0, 31)), rb[2:0]});
			write_reg(REG_WTHROUGH, {7'($urandom_range(0, 127)), ph[0]});
			write_reg(REG_WALLOC, {7'($urandom_range(0, 127)), ~ph[1]});
			n = (ph == 11) ? 70 : 97;
			for (int k = 0; k < n; k++) send_access(random_access(), 1'b0, '0);
			drain();
		end
		quiet = 0;

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sacr_pkg.sv
hdl/sacr_ctrl.sv
hdl/sacr_dp.sv
hdl/set_assoc_cache_rrip_replacement.sv
hdl/sacr_chk.sv
test/tb_set_assoc_cache_rrip_replacement.sv
